@@ rtl/alhc_pkg.sv @@
// ----------------------------------------------------------------------------
// alhc_pkg
// Shared constants and types for the averaged level hysteresis counter:
// threshold width, reset values and configuration register indexes.
// ----------------------------------------------------------------------------
package alhc_pkg;

    localparam int THRESH_BITS    = 10;
    localparam int CFG_INDEX_BITS = 1;

    typedef logic [THRESH_BITS-1:0]    thresh_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_EMPTY_THRESHOLD = 1'd0;
    localparam cfg_index_t REG_FULL_THRESHOLD  = 1'd1;

    localparam thresh_t EMPTY_THRESHOLD_RESET = 10'd200;
    localparam thresh_t FULL_THRESHOLD_RESET  = 10'd900;

endpackage

@@ rtl/alhc_if.sv @@
// ----------------------------------------------------------------------------
// alhc_if
// Valid/ready channels of the averaged level hysteresis counter: one for
// input items, one for results.
// ----------------------------------------------------------------------------
interface alhc_in_if #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [SAMPLE_BITS-1:0] sample;
    logic [COUNT_BITS-1:0]  new_count;

    modport source (output valid, output mode, output sample, output new_count, input ready);
    modport sink   (input valid, input mode, input sample, input new_count, output ready);
endinterface

interface alhc_out_if #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] average;
    logic                   armed;
    logic [COUNT_BITS-1:0]  event_count;
    logic                   new_event;

    modport source (output valid, output average, output armed, output event_count,
                    output new_event, input ready);
    modport sink   (input valid, input average, input armed, input event_count,
                    input new_event, output ready);
endinterface

@@ rtl/averaged_level_hysteresis_counter.sv @@
// ----------------------------------------------------------------------------
// averaged_level_hysteresis_counter
// Moving average over the last WINDOW samples with a hysteresis flag and a
// saturating refill counter.
//
// Usage:
//   item   : input channel. mode 0 transfers a sensor sample, mode 1 loads
//            the event counter with new_count (load zero to clear it).
//   result : one transfer per item: average, armed flag, event count and a
//            new_event strobe.
//   cfg    : write port for empty_threshold (index 0) and full_threshold
//            (index 1); write only while the block is idle.
//   A sample passes these steps before the next input slot frees: the oldest
//   sample is read from the ring memory as the item is taken, the sum is
//   updated and the ring written, the radix-4 divider forms sum / fill count,
//   and the thresholds are applied. A load item goes straight to the
//   last step. The result register is filled in that last step.
//   If the result is stalled, the block holds the finished item until the
//   register frees. After reset the ring is empty, the counter, flag and
//   average are zero, and the thresholds are 200 and 900.
// ----------------------------------------------------------------------------
module averaged_level_hysteresis_counter #(
    parameter int WINDOW      = 20,
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    alhc_in_if.sink                       item,
    alhc_out_if.source                    result,
    input  logic                          cfg_we,
    input  alhc_pkg::cfg_index_t          cfg_index,
    input  alhc_pkg::thresh_t             cfg_data
);

    localparam int FILL_BITS = $clog2(WINDOW + 1);
    localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + FILL_BITS;
    localparam int QW        = SAMPLE_BITS + (SAMPLE_BITS % 2);
    localparam int STEPS     = QW / 2;
    localparam int STEP_BITS = $clog2(STEPS);
    localparam int CMP_BITS  = (SAMPLE_BITS > alhc_pkg::THRESH_BITS) ?
                               SAMPLE_BITS : alhc_pkg::THRESH_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // ring memory
    logic [SAMPLE_BITS-1:0] sample_ring [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    // control state
    logic [1:0]             state_reg, state_next;
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic                   armed_reg, armed_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;
    alhc_pkg::thresh_t      empty_thr_reg, empty_thr_next;
    alhc_pkg::thresh_t      full_thr_reg, full_thr_next;
    logic                   out_valid_reg, out_valid_next;

    // payload
    logic                   mode_reg, mode_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [COUNT_BITS-1:0]  load_reg, load_next;
    logic [FILL_BITS-1:0]   rem_reg, rem_next;
    logic [QW-1:0]          quo_reg, quo_next;
    logic [SAMPLE_BITS-1:0] out_avg_reg, out_avg_next;
    logic                   out_armed_reg, out_armed_next;
    logic [COUNT_BITS-1:0]  out_count_reg, out_count_next;
    logic                   out_event_reg, out_event_next;

    // datapath
    logic                   ring_full;
    logic                   ring_we;
    logic [SUM_BITS-1:0]    sum_upd;
    logic [SUM_BITS-1:0]    sum_hi;
    logic [FILL_BITS:0]     t1, t2, d_ext;
    logic                   ge1, ge2;
    logic [FILL_BITS:0]     r1;
    logic [FILL_BITS:0]     r2;
    logic                   out_free;
    logic [CMP_BITS-1:0]    avg_cmp, empty_cmp, full_cmp;
    logic                   event_hit;

    assign ring_full = (fill_reg == FILL_BITS'(WINDOW));
    assign ring_we   = (state_reg == ST_READ);
    assign out_free  = !out_valid_reg || result.ready;

    assign sum_upd = sum_reg - (ring_full ? SUM_BITS'(rd_data_reg) : '0)
                     + SUM_BITS'(sample_reg);
    assign sum_hi  = sum_upd >> QW;

    // two restoring steps per cycle
    assign d_ext = {1'b0, fill_reg};
    assign t1    = {rem_reg, quo_reg[QW-1]};
    assign ge1   = (t1 >= d_ext);
    assign r1    = ge1 ? (t1 - d_ext) : t1;
    assign t2    = {r1[FILL_BITS-1:0], quo_reg[QW-2]};
    assign ge2   = (t2 >= d_ext);
    assign r2    = ge2 ? (t2 - d_ext) : t2;

    assign avg_cmp   = CMP_BITS'(quo_reg[SAMPLE_BITS-1:0]);
    assign empty_cmp = CMP_BITS'(empty_thr_reg);
    assign full_cmp  = CMP_BITS'(full_thr_reg);

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        armed_next     = armed_reg;
        count_next     = count_reg;
        avg_next       = avg_reg;
        step_next      = step_reg;
        empty_thr_next = empty_thr_reg;
        full_thr_next  = full_thr_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        sample_next    = sample_reg;
        load_next      = load_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_avg_next   = out_avg_reg;
        out_armed_next = out_armed_reg;
        out_count_next = out_count_reg;
        out_event_next = out_event_reg;
        event_hit      = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                alhc_pkg::REG_EMPTY_THRESHOLD: empty_thr_next = cfg_data;
                alhc_pkg::REG_FULL_THRESHOLD:  full_thr_next  = cfg_data;
            endcase
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    mode_next   = item.mode;
                    sample_next = item.sample;
                    load_next   = item.new_count;
                    state_next  = item.mode ? ST_DONE : ST_READ;
                end
            end
            ST_READ:
            begin
                sum_next  = sum_upd;
                fill_next = ring_full ? fill_reg : fill_reg + 1'b1;
                slot_next = (slot_reg == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                rem_next  = sum_hi[FILL_BITS-1:0];
                quo_next  = QW'(sum_upd);
                step_next = STEP_BITS'(STEPS - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = r2[FILL_BITS-1:0];
                quo_next = {quo_reg[QW-3:0], ge1, ge2};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (mode_reg)
                    begin
                        count_next = load_reg;
                    end
                    else
                    begin
                        avg_next = quo_reg[SAMPLE_BITS-1:0];
                        priority if (!armed_reg && (avg_cmp < empty_cmp))
                        begin
                            armed_next = 1'b1;
                        end
                        else if (armed_reg && (avg_cmp >= full_cmp))
                        begin
                            armed_next = 1'b0;
                            if (count_reg != '1)
                            begin
                                count_next = count_reg + 1'b1;
                                event_hit  = 1'b1;
                            end
                        end
                    end
                    out_valid_next = 1'b1;
                    out_avg_next   = avg_next;
                    out_armed_next = armed_next;
                    out_count_next = count_next;
                    out_event_next = event_hit;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            armed_reg     <= 1'b0;
            count_reg     <= '0;
            avg_reg       <= '0;
            step_reg      <= '0;
            empty_thr_reg <= alhc_pkg::EMPTY_THRESHOLD_RESET;
            full_thr_reg  <= alhc_pkg::FULL_THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            armed_reg     <= armed_next;
            count_reg     <= count_next;
            avg_reg       <= avg_next;
            step_reg      <= step_next;
            empty_thr_reg <= empty_thr_next;
            full_thr_reg  <= full_thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        sample_reg    <= sample_next;
        load_reg      <= load_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        out_avg_reg   <= out_avg_next;
        out_armed_reg <= out_armed_next;
        out_count_reg <= out_count_next;
        out_event_reg <= out_event_next;
    end

    // ring: one write port, registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            sample_ring[slot_reg] <= sample_reg;
        end
        rd_data_reg <= sample_ring[slot_reg];
    end

    assign item.ready         = (state_reg == ST_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.average     = out_avg_reg;
    assign result.armed       = out_armed_reg;
    assign result.event_count = out_count_reg;
    assign result.new_event   = out_event_reg;

endmodule

@@ test/averaged_level_hysteresis_counter_tb.sv @@
// ----------------------------------------------------------------------------
// averaged_level_hysteresis_counter_tb
// Drives sensor samples and counter loads through the item channel with random
// gaps and result back-pressure, predicts each result from a local model of
// the moving average, hysteresis flag and saturating counter, and checks each
// result transfer field by field. Threshold pairs change between phases.
// ----------------------------------------------------------------------------
module averaged_level_hysteresis_counter_tb;

    localparam int WINDOW   = 20;
    localparam int SAMPLE_W = 10;
    localparam int COUNT_W  = 16;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;

    typedef struct packed {
        logic                mode;
        logic [SAMPLE_W-1:0] sample;
        logic [COUNT_W-1:0]  new_count;
    } sensor_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                armed;
        logic [COUNT_W-1:0]  event_count;
        logic                new_event;
    } level_result_t;

    logic                 clk;
    logic                 rst_n = 1'b1;
    logic                 cfg_we;
    alhc_pkg::cfg_index_t cfg_index;
    alhc_pkg::thresh_t    cfg_data;

    alhc_in_if  #(.SAMPLE_BITS(SAMPLE_W), .COUNT_BITS(COUNT_W)) item_ch ();
    alhc_out_if #(.SAMPLE_BITS(SAMPLE_W), .COUNT_BITS(COUNT_W)) result_ch ();

    averaged_level_hysteresis_counter #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_W),
        .COUNT_BITS  (COUNT_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sensor_item_t  pending_items[$];
    level_result_t expected_levels[$];
    int            fail_count = 0;

    // local copy of the block state
    logic [SAMPLE_W-1:0] level_ring [WINDOW];
    int                  ring_slot  = 0;
    int                  ring_fill  = 0;
    int                  level_sum  = 0;
    logic [SAMPLE_W-1:0] mean_level = '0;
    bit                  armed_flag = 1'b0;
    logic [COUNT_W-1:0]  glass_count = '0;
    alhc_pkg::thresh_t   empty_level = alhc_pkg::EMPTY_THRESHOLD_RESET;
    alhc_pkg::thresh_t   full_level  = alhc_pkg::FULL_THRESHOLD_RESET;

    int            stretch_left [2] = '{0, 0};
    bit            stretch_quiet[2] = '{1'b0, 1'b0};
    int            send_gap;
    int            recv_stall;
    sensor_item_t  next_item;
    level_result_t want;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic void predict_level(input logic mode, input logic [SAMPLE_W-1:0] s,
                                          input logic [COUNT_W-1:0] count);
        level_result_t r;
        r = '0;
        if (mode == MODE_LOAD)
            glass_count = count;
        else
        begin
            if (ring_fill == WINDOW)
                level_sum -= int'(level_ring[ring_slot]);
            else
                ring_fill++;
            level_ring[ring_slot] = s;
            level_sum += int'(s);
            ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
            mean_level = SAMPLE_W'(level_sum / ring_fill);
            if (!armed_flag && mean_level < empty_level)
                armed_flag = 1'b1;
            else if (armed_flag && mean_level >= full_level)
            begin
                armed_flag = 1'b0;
                if (glass_count != '1)
                begin
                    glass_count++;
                    r.new_event = 1'b1;
                end
            end
        end
        r.average     = mean_level;
        r.armed       = armed_flag;
        r.event_count = glass_count;
        expected_levels.push_back(r);
    endfunction

    // stretches of back-to-back traffic between stretches of random waits
    function automatic int draw_wait(input int side);
        if (stretch_left[side] == 0)
        begin
            stretch_left[side]  = $urandom_range(1, 40);
            stretch_quiet[side] = ($urandom_range(0, 3) == 0);
        end
        stretch_left[side]--;
        return stretch_quiet[side] ? 0 : $urandom_range(0, 16);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid     <= 1'b0;
            item_ch.mode      <= MODE_SAMPLE;
            item_ch.sample    <= '0;
            item_ch.new_count <= '0;
            send_gap = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                predict_level(item_ch.mode, item_ch.sample, item_ch.new_count);
            if (!item_ch.valid || item_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.mode      <= next_item.mode;
                    item_ch.sample    <= next_item.sample;
                    item_ch.new_count <= next_item.new_count;
                    send_gap = draw_wait(SIDE_SEND);
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    $error("unexpected result transfer: average %0d", result_ch.average);
                    fail_count++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (result_ch.average !== want.average)
                    begin
                        $error("average: expected %0d, actual %0d",
                               want.average, result_ch.average);
                        fail_count++;
                    end
                    if (result_ch.armed !== want.armed)
                    begin
                        $error("armed: expected %0d, actual %0d", want.armed, result_ch.armed);
                        fail_count++;
                    end
                    if (result_ch.event_count !== want.event_count)
                    begin
                        $error("event_count: expected %0d, actual %0d",
                               want.event_count, result_ch.event_count);
                        fail_count++;
                    end
                    if (result_ch.new_event !== want.new_event)
                    begin
                        $error("new_event: expected %0d, actual %0d",
                               want.new_event, result_ch.new_event);
                        fail_count++;
                    end
                end
                recv_stall = draw_wait(SIDE_RECV);
            end
            if (recv_stall != 0)
            begin
                recv_stall--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic queue_item(input logic mode, input logic [SAMPLE_W-1:0] s,
                              input logic [COUNT_W-1:0] count);
        sensor_item_t it;
        it.mode      = mode;
        it.sample    = s;
        it.new_count = count;
        pending_items.push_back(it);
    endtask

    task automatic write_threshold(input alhc_pkg::cfg_index_t idx,
                                   input alhc_pkg::thresh_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == alhc_pkg::REG_EMPTY_THRESHOLD)
            empty_level = value;
        else
            full_level = value;
    endtask

    task automatic set_thresholds(input alhc_pkg::thresh_t empty_value,
                                  input alhc_pkg::thresh_t full_value);
        write_threshold(alhc_pkg::REG_EMPTY_THRESHOLD, empty_value);
        write_threshold(alhc_pkg::REG_FULL_THRESHOLD, full_value);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_levels.size() != 0 || item_ch.valid)
            @(posedge clk);
    endtask

    // runs of low and high readings so the average crosses both thresholds,
    // with noise samples and counter loads, some close to saturation
    task automatic queue_random(input int n);
        int  k;
        int  pick;
        int  run_left;
        bit  high_run;
        run_left = 0;
        high_run = 1'b0;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 1)
                queue_item(MODE_LOAD, SAMPLE_W'($urandom), '0);
            else if (pick < 3)
                queue_item(MODE_LOAD, SAMPLE_W'($urandom),
                           COUNT_W'(16'hFFFF - $urandom_range(0, 2)));
            else if (pick < 6)
                queue_item(MODE_LOAD, SAMPLE_W'($urandom), COUNT_W'($urandom));
            else if (pick < 16)
                queue_item(MODE_SAMPLE, SAMPLE_W'($urandom), COUNT_W'($urandom));
            else
            begin
                if (run_left == 0)
                begin
                    run_left = $urandom_range(3, 30);
                    high_run = !high_run;
                end
                run_left--;
                queue_item(MODE_SAMPLE,
                           high_run ? SAMPLE_W'($urandom_range(900, 1023))
                                    : SAMPLE_W'($urandom_range(0, 120)),
                           COUNT_W'($urandom));
            end
        end
        drain();
    endtask

    initial
    begin
        int k;
        cfg_we    = 1'b0;
        cfg_index = alhc_pkg::REG_EMPTY_THRESHOLD;
        cfg_data  = '0;
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset thresholds: arm on an empty reading, count once the mean reaches full
        queue_item(MODE_LOAD, '0, '0);
        queue_item(MODE_SAMPLE, '0, '1);
        for (k = 0; k < 12; k++)
            queue_item(MODE_SAMPLE, '1, '0);
        queue_item(MODE_LOAD, '1, '1);
        drain();

        // flag toggles on every sample; counter saturates; ring wraps
        set_thresholds(10'd1023, 10'd0);
        queue_item(MODE_LOAD, '0, 16'hFFFE);
        for (k = 0; k < 4; k++)
            queue_item(MODE_SAMPLE, 10'd5, '0);
        queue_item(MODE_LOAD, '0, '0);
        for (k = 0; k < 4; k++)
            queue_item(MODE_SAMPLE, '1, '0);
        drain();

        queue_random(150);
        set_thresholds(10'd0, 10'd1023);
        queue_random(150);
        set_thresholds(alhc_pkg::EMPTY_THRESHOLD_RESET, alhc_pkg::FULL_THRESHOLD_RESET);
        queue_random(300);
        for (k = 0; k < 4; k++)
        begin
            set_thresholds(alhc_pkg::thresh_t'($urandom_range(0, 600)),
                           alhc_pkg::thresh_t'($urandom_range(400, 1023)));
            queue_random(250);
        end
        set_thresholds(10'd512, 10'd512);
        queue_random(150);

        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS averaged_level_hysteresis_counter");
        else
            $display("FAIL averaged_level_hysteresis_counter");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL averaged_level_hysteresis_counter");
        $finish;
    end

endmodule

@@ averaged_level_hysteresis_counter.f @@
rtl/alhc_pkg.sv
rtl/alhc_if.sv
rtl/averaged_level_hysteresis_counter.sv
test/averaged_level_hysteresis_counter_tb.sv
